// ===== src/mck_pkg.sv =====
// Shared types, constants and character table for the Morse character keyer.
package mck_pkg;

   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned UNITS_W    = 3;
   localparam int unsigned CYCLES_W   = 8;
   localparam int unsigned DUR_W      = 10;
   localparam int unsigned LEN_W      = 3;
   localparam int unsigned PAT_W      = 4;
   localparam int unsigned IDX_W      = 2;
   localparam int unsigned RSP_DATA_W = 16;

   localparam logic [CYCLES_W-1:0] UNIT_CYCLES_RESET = 8'd8;

   localparam logic [UNITS_W-1:0] DOT_UNITS        = 3'd1;
   localparam logic [UNITS_W-1:0] DASH_UNITS       = 3'd3;
   localparam logic [UNITS_W-1:0] ELEM_GAP_UNITS   = 3'd1;
   localparam logic [UNITS_W-1:0] LETTER_GAP_UNITS = 3'd3;
   localparam logic [UNITS_W-1:0] WORD_GAP_UNITS   = 3'd4;
   localparam logic [UNITS_W-1:0] UNSUP_UNITS      = 3'd0;

   typedef enum logic [1:0] {
      KIND_LETTER,
      KIND_SPACE,
      KIND_UNSUP
   } char_kind_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_MARK,
      EMIT_GAP,
      EMIT_SINGLE
   } emit_type;

   typedef struct packed {
      char_kind_type          kind;
      logic [LEN_W-1:0]       len;
      logic [PAT_W-1:0]       dashes;   // bit i set: mark i is a dash
   } char_info_type;

   typedef struct packed {
      logic     load;
      emit_type emit;
   } mck_cmd_type;

   typedef struct packed {
      logic out_free;
      logic single;
      logic final_mark;
   } mck_status_type;

   function automatic char_info_type decode_char(input logic [CHAR_W-1:0] c);
      char_info_type info;
      info = '{kind: KIND_LETTER, len: 3'd0, dashes: 4'h0};
      case (c)
         " ":     info = '{kind: KIND_SPACE, len: 3'd0, dashes: 4'h0};
         "n":     info.len = 3'd2;
         "i":     info.len = 3'd2;
         "k":     begin info.len = 3'd3; info.dashes = 4'h5; end
         "t":     begin info.len = 3'd1; info.dashes = 4'h1; end
         "a":     begin info.len = 3'd2; info.dashes = 4'h2; end
         "h":     info.len = 3'd4;
         "e":     info.len = 3'd1;
         "l":     begin info.len = 3'd4; info.dashes = 4'h2; end
         "o":     begin info.len = 3'd3; info.dashes = 4'h7; end
         "w":     begin info.len = 3'd3; info.dashes = 4'h6; end
         "r":     begin info.len = 3'd3; info.dashes = 4'h2; end
         "d":     begin info.len = 3'd3; info.dashes = 4'h1; end
         default: info = '{kind: KIND_UNSUP, len: 3'd0, dashes: 4'h0};
      endcase
      if (c == "n") begin
         info.dashes = 4'h1;
      end
      return info;
   endfunction

endpackage

// ===== src/morse_character_keyer.sv =====
// Top level of the Morse character keyer: sequencer plus datapath.
//
//  channel  dir  handshake             payload
//  req      in   req_tvalid/tready     tdata[7:0] char_code
//  rsp      out  rsp_tvalid/tready     tdata: key_on, unit_count, duration_cycles,
//                                      unsupported; tlast: last
//  csr      in   csr_valid/csr_ready   csr_data[7:0] unit_cycles
//
// A letter is one load and then one beat per element (each mark and each gap);
// space and unsupported codes are one load and one beat. The sequencer handles
// one character at a time. rsp stalls hold the sequencer in place; the output
// register lets the next element be built as soon as the current beat is taken.
// Synchronous active-high reset; unit_cycles resets to 8.
module morse_character_keyer
   import mck_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CHAR_W-1:0]     req_tdata,   // [7:0] char_code
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] key_on, [3:1] unit_count,
                                              // [13:4] duration_cycles, [14] unsupported
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CYCLES_W-1:0]   csr_data
);

   mck_cmd_type         cmd;
   mck_status_type      status;
   logic                key_on, unsupported;
   logic [UNITS_W-1:0]  unit_count;
   logic [DUR_W-1:0]    duration_cycles;

   assign csr_ready = 1'b1;

   mck_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mck_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .char_code       (req_tdata),
      .csr_we          (csr_valid & csr_ready),
      .csr_data        (csr_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .key_on          (key_on),
      .unit_count      (unit_count),
      .duration_cycles (duration_cycles),
      .unsupported     (unsupported),
      .last            (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, unsupported, duration_cycles, unit_count, key_on};

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("keyer ready right after accepting a character");

   a_unsup_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && unsupported) |-> (rsp_tlast && unit_count == UNSUP_UNITS && !key_on))
      else $error("unsupported beat malformed");

   a_mark_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && key_on) |-> !rsp_tlast)
      else $error("mark flagged as last");

   a_word_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && unit_count == WORD_GAP_UNITS) |-> (rsp_tlast && !key_on))
      else $error("word gap malformed");

endmodule

// ===== src/mck_ctrl.sv =====
// Sequencer for the Morse character keyer: steps marks and gaps of one character.
module mck_ctrl
   import mck_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  mck_status_type status,
   output mck_cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MARK,
      S_GAP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '{load: 1'b0, emit: EMIT_NONE};
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MARK;
            end
         end
         S_MARK: begin
            if (status.out_free) begin
               if (status.single) begin
                  cmd.emit = EMIT_SINGLE;
                  state_in = S_IDLE;
               end else begin
                  cmd.emit = EMIT_MARK;
                  state_in = S_GAP;
               end
            end
         end
         S_GAP: begin
            if (status.out_free) begin
               cmd.emit = EMIT_GAP;
               state_in = status.final_mark ? S_IDLE : S_MARK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/mck_dp.sv =====
// Datapath for the Morse character keyer: character registers, element build, output beat.
module mck_dp
   import mck_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CHAR_W-1:0]     char_code,
   input  logic                  csr_we,
   input  logic [CYCLES_W-1:0]   csr_data,
   input  mck_cmd_type           cmd,
   output mck_status_type        status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  key_on,
   output logic [UNITS_W-1:0]    unit_count,
   output logic [DUR_W-1:0]      duration_cycles,
   output logic                  unsupported,
   output logic                  last
);

   logic [CYCLES_W-1:0] unit_cycles_ff;
   char_info_type       info_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic                valid_ff;
   logic                key_ff, unsup_ff, last_ff;
   logic [UNITS_W-1:0]  units_ff;
   logic [DUR_W-1:0]    dur_ff;

   logic                final_mark;
   logic                is_dash;
   logic                e_key, e_unsup, e_last;
   logic [UNITS_W-1:0]  e_units;
   logic [UNITS_W+CYCLES_W-1:0] e_prod;

   assign final_mark = ((LEN_W'(idx_ff) + LEN_W'(1)) == info_ff.len);
   assign is_dash    = info_ff.dashes[idx_ff];

   always_comb begin
      e_key   = 1'b0;
      e_unsup = 1'b0;
      e_last  = 1'b0;
      e_units = UNSUP_UNITS;
      case (cmd.emit)
         EMIT_MARK: begin
            e_key   = 1'b1;
            e_units = is_dash ? DASH_UNITS : DOT_UNITS;
         end
         EMIT_GAP: begin
            e_units = final_mark ? LETTER_GAP_UNITS : ELEM_GAP_UNITS;
            e_last  = final_mark;
         end
         EMIT_SINGLE: begin
            e_last = 1'b1;
            if (info_ff.kind == KIND_SPACE) begin
               e_units = WORD_GAP_UNITS;
            end else begin
               e_unsup = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign e_prod = (UNITS_W+CYCLES_W)'(e_units) * (UNITS_W+CYCLES_W)'(unit_cycles_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_cycles_ff <= UNIT_CYCLES_RESET;
         valid_ff       <= 1'b0;
      end else begin
         if (csr_we) begin
            unit_cycles_ff <= csr_data;
         end
         if (cmd.emit != EMIT_NONE) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         info_ff <= decode_char(char_code);
         idx_ff  <= '0;
      end else if (cmd.emit == EMIT_GAP && !final_mark) begin
         idx_ff  <= idx_ff + IDX_W'(1);
      end
      if (cmd.emit != EMIT_NONE) begin
         key_ff   <= e_key;
         units_ff <= e_units;
         dur_ff   <= e_prod[DUR_W-1:0];
         unsup_ff <= e_unsup;
         last_ff  <= e_last;
      end
   end

   assign status = '{out_free:   (!valid_ff || rsp_ready),
                     single:     (info_ff.kind != KIND_LETTER),
                     final_mark: final_mark};

   assign rsp_valid       = valid_ff;
   assign key_on          = key_ff;
   assign unit_count      = units_ff;
   assign duration_cycles = dur_ff;
   assign unsupported     = unsup_ff;
   assign last            = last_ff;

endmodule
